FILE: src/i2a_pkg.sv
// shared types, constants and helpers of the integer to ascii radix converter
`default_nettype none
package i2a_pkg;

	localparam int VALUE_W   = 32;
	localparam int RADIX_W   = 5;
	localparam int DIGIT_W   = 4;
	localparam int CHAR_W    = 8;
	// one digit cell per bit covers radix 2
	localparam int NUM_CELLS = VALUE_W;
	localparam int CNT_W     = $clog2(2 * NUM_CELLS);
	// count value in the conversion state at which the last cell takes in its final bit
	localparam int CONV_LAST = 2 * NUM_CELLS - 2;

	localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(16);
	localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h37; // 'A' - 10

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [RADIX_W-1:0] radix;
		logic               signed_mode;
	} in_req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last_char;
	} out_req_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_CONV,
		CELL_SHIFT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t         mode;
		logic [RADIX_W-1:0] radix;
	} cell_ctrl_t;

	// quotient bit stream between neighboring cells
	typedef struct packed {
		logic valid;
		logic qbit;
	} cell_link_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = CHAR_W'(d);
		if (d < DIGIT_W'(10)) begin
			return ext + CHAR_ZERO;
		end
		return ext + CHAR_ALPHA;
	endfunction

endpackage
`default_nettype wire

FILE: src/i2a_cell.sv
// one digit cell: doubles its digit plus the incoming bit modulo radix, passes the quotient on
`default_nettype none
module i2a_cell (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire i2a_pkg::cell_ctrl_t              ctrl,
	input  wire i2a_pkg::cell_link_t              link_in,
	input  wire logic [i2a_pkg::DIGIT_W-1:0]      digit_in,
	output i2a_pkg::cell_link_t                   link_out,
	output logic [i2a_pkg::DIGIT_W-1:0]           digit
);

	logic [i2a_pkg::DIGIT_W-1:0] digit_q;
	i2a_pkg::cell_link_t         link_q;
	logic [i2a_pkg::DIGIT_W:0]   dbl;
	logic [i2a_pkg::DIGIT_W:0]   diff;
	logic                        ge;

	// 2*d + b stays below 2*radix, so one compare and subtract reduces it
	assign dbl  = {digit_q, link_in.qbit};
	assign ge   = dbl >= ctrl.radix;
	assign diff = dbl - ctrl.radix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			unique case (ctrl.mode)
				i2a_pkg::CELL_CLEAR: link_q <= '0;
				i2a_pkg::CELL_CONV: begin
					link_q.valid <= link_in.valid;
					link_q.qbit  <= ge;
				end
				i2a_pkg::CELL_SHIFT: link_q.valid <= 1'b0;
				i2a_pkg::CELL_HOLD:  link_q.valid <= 1'b0;
				default:             link_q.valid <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.mode)
			i2a_pkg::CELL_CLEAR: digit_q <= '0;
			i2a_pkg::CELL_CONV: begin
				if (link_in.valid) begin
					digit_q <= ge ? diff[i2a_pkg::DIGIT_W-1:0] : dbl[i2a_pkg::DIGIT_W-1:0];
				end
			end
			i2a_pkg::CELL_SHIFT: digit_q <= digit_in;
			i2a_pkg::CELL_HOLD:  digit_q <= digit_q;
			default:             digit_q <= digit_q;
		endcase
	end

	assign link_out = link_q;
	assign digit    = digit_q;

endmodule
`default_nettype wire

FILE: src/integer_to_ascii_radix_core.sv
// top level: itoa style converter built from a row of radix digit cells
//
// in channel (in_valid/in_ready/in_data) takes one request: a 32-bit value,
// a radix (0 and 1 act as 2, 17 and up act as 16) and a signed flag.
// out channel (out_valid/out_ready/out_data) returns the text, one ascii
// character per transfer, most significant first, last_char on the final one.
// a negative signed value gets a leading '-'; 0x80000000 in signed mode prints as -2147483648.
//
// the value enters a row of 32 digit cells one bit per cycle, msb first;
// each cell hands its quotient bit on to the next one through a register.
// leading zero digits are then shifted out of the top cell one per cycle,
// and the remaining digits leave the top cell one per cycle while the
// output register is free. the next request is accepted the cycle after
// the last character is loaded.
// a stalled receiver freezes the character sequence; nothing is dropped.
// in_ready is high only while the block is idle.
// reset clears the controller and the output valid flag; no request is pending.
`default_nettype none
module integer_to_ascii_radix_core (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  wire i2a_pkg::in_req_t in_data,
	output logic                 out_valid,
	input  wire                  out_ready,
	output i2a_pkg::out_req_t    out_data
);

	localparam int NC = i2a_pkg::NUM_CELLS;
	localparam int PW = $clog2(NC + 1);

	i2a_pkg::state_t                 state_q, state_d;
	logic [i2a_pkg::VALUE_W-1:0]     mag_q;
	logic [i2a_pkg::RADIX_W-1:0]     radix_q;
	logic                            minus_q;
	logic [i2a_pkg::CNT_W-1:0]       cnt_q;
	logic [PW-1:0]                   pos_q;      // digit positions still in the row
	logic                            out_valid_q;
	i2a_pkg::out_req_t               out_q;

	i2a_pkg::cell_ctrl_t             cell_ctrl;
	i2a_pkg::cell_link_t             feed;
	i2a_pkg::cell_link_t             link [NC];
	logic [i2a_pkg::DIGIT_W-1:0]     digit [NC];
	logic [i2a_pkg::DIGIT_W-1:0]     top_digit;

	logic                            take;
	logic                            in_minus;
	logic [i2a_pkg::RADIX_W-1:0]     in_radix;
	logic                            out_free;
	logic                            out_load;
	i2a_pkg::out_req_t               out_d;

	assign take      = in_valid && in_ready;
	assign in_minus  = in_data.signed_mode && in_data.value[i2a_pkg::VALUE_W-1];
	assign out_free  = !out_valid_q || out_ready;
	assign top_digit = digit[NC-1];

	// clamp the radix into 2..16
	always_comb begin
		priority if (in_data.radix < i2a_pkg::RADIX_MIN) begin
			in_radix = i2a_pkg::RADIX_MIN;
		end else if (in_data.radix > i2a_pkg::RADIX_MAX) begin
			in_radix = i2a_pkg::RADIX_MAX;
		end else begin
			in_radix = in_data.radix;
		end
	end

	// row of digit cells, cell 0 holds the least significant digit
	for (genvar i = 0; i < NC; i++) begin : g_cell
		if (i == 0) begin : g_first
			i2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.link_in  (feed),
				.digit_in ('0),
				.link_out (link[i]),
				.digit    (digit[i])
			);
		end else begin : g_next
			i2a_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (cell_ctrl),
				.link_in  (link[i-1]),
				.digit_in (digit[i-1]),
				.link_out (link[i]),
				.digit    (digit[i])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, cell control and output loading
	always_comb begin
		state_d         = state_q;
		in_ready        = 1'b0;
		cell_ctrl.mode  = i2a_pkg::CELL_HOLD;
		cell_ctrl.radix = radix_q;
		feed.valid      = 1'b0;
		feed.qbit       = mag_q[i2a_pkg::VALUE_W-1];
		out_load        = 1'b0;
		out_d.character = i2a_pkg::digit_glyph(top_digit);
		out_d.last_char = (pos_q == PW'(1));
		unique case (state_q)
			i2a_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cell_ctrl.mode = i2a_pkg::CELL_CLEAR;
					state_d        = i2a_pkg::ST_CONV;
				end
			end
			i2a_pkg::ST_CONV: begin
				cell_ctrl.mode = i2a_pkg::CELL_CONV;
				// bits enter only while the count is below VALUE_W
				feed.valid     = (cnt_q < i2a_pkg::CNT_W'(i2a_pkg::VALUE_W));
				if (cnt_q == i2a_pkg::CNT_W'(i2a_pkg::CONV_LAST)) begin
					state_d = i2a_pkg::ST_SKIP;
				end
			end
			i2a_pkg::ST_SKIP: begin
				// drop leading zeros but always keep one digit
				if (top_digit == '0 && pos_q != PW'(1)) begin
					cell_ctrl.mode = i2a_pkg::CELL_SHIFT;
				end else begin
					state_d = minus_q ? i2a_pkg::ST_SIGN : i2a_pkg::ST_EMIT;
				end
			end
			i2a_pkg::ST_SIGN: begin
				out_d.character = i2a_pkg::CHAR_MINUS;
				out_d.last_char = 1'b0;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = i2a_pkg::ST_EMIT;
				end
			end
			i2a_pkg::ST_EMIT: begin
				if (out_free) begin
					out_load       = 1'b1;
					cell_ctrl.mode = i2a_pkg::CELL_SHIFT;
					if (pos_q == PW'(1)) begin
						state_d = i2a_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = i2a_pkg::ST_IDLE;
		endcase
	end

	// request operands and sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
		end else begin
			if (take) begin
				cnt_q <= '0;
				pos_q <= PW'(NC);
			end else begin
				if (state_q == i2a_pkg::ST_CONV) begin
					cnt_q <= cnt_q + i2a_pkg::CNT_W'(1);
				end
				if (cell_ctrl.mode == i2a_pkg::CELL_SHIFT) begin
					pos_q <= pos_q - PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			// negation wraps, so the most negative value gives 2^31
			mag_q   <= in_minus ? (~in_data.value + i2a_pkg::VALUE_W'(1)) : in_data.value;
			radix_q <= in_radix;
			minus_q <= in_minus;
		end else if (state_q == i2a_pkg::ST_CONV) begin
			mag_q <= {mag_q[i2a_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	// output register holds the current character while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// the magnitude always fits the row, so the top cell never carries out a one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		link[NC-1].valid |-> !link[NC-1].qbit)
		else $error("digit row overflow");

	// leaving the zero skip, the top digit is significant unless it is the only one
	a_skip_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_SKIP && state_d != i2a_pkg::ST_SKIP)
			|-> (pos_q == PW'(1) || top_digit != '0))
		else $error("leading zero left in the text");

	// a character is only loaded while digits remain
	a_pos_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (pos_q != '0 && pos_q <= PW'(NC)))
		else $error("character loaded with no digit left");

	// the last character ends the request and returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_d.last_char) |=> (state_q == i2a_pkg::ST_IDLE))
		else $error("block busy after the last character");

endmodule
`default_nettype wire
